// ===== src/assert_macros.svh =====
// Assertion macros for the vector table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, a, c)
`define ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== src/bvte_pkg.sv =====
// ----------------------------------------------------------------------------
// bvte_pkg
// Shared constants and codes for the vector table engine.
// ----------------------------------------------------------------------------
package bvte_pkg;
  localparam int DEPTH = 64;
  localparam int WORD_BITS = 32;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [3:0] OP_PUSH = 4'd0;
  localparam logic [3:0] OP_POP = 4'd1;
  localparam logic [3:0] OP_INS = 4'd2;
  localparam logic [3:0] OP_DEL = 4'd3;
  localparam logic [3:0] OP_READ = 4'd4;
  localparam logic [3:0] OP_WRITE = 4'd5;
  localparam logic [3:0] OP_FIND = 4'd6;
  localparam logic [3:0] OP_COUNT = 4'd7;
  localparam logic [3:0] OP_ALLEQ = 4'd8;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOB = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic we;
    logic [AW-1:0] waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

// ===== src/bvte_ram.sv =====
// ----------------------------------------------------------------------------
// bvte_ram
// Single-port-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bvte_ram (
  input  logic clk,
  input  bvte_pkg::mem_req_t req,
  output logic [bvte_pkg::WORD_BITS-1:0] rdata
);
  logic [bvte_pkg::WORD_BITS-1:0] mem [bvte_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== src/bounded_vector_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_vector_table_engine_unit
// Ordered table of words with push, pop, insert, delete, read, write,
// find, count and all-equal, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low; its result word shows for
// one cycle with done. The receiver cannot stall. Push, write, unknown codes
// and errors go straight to the result; pop and read first read the RAM;
// insert and delete read and then move the later entries one at a time;
// find, count and all-equal scan up to 64 entries one at a time. No new item
// is taken while busy.
`include "assert_macros.svh"
module bounded_vector_table_engine_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [3:0] opcode,
  input  logic [5:0] position,
  input  logic [31:0] word,
  output logic done,
  output logic [31:0] read_word,
  output logic [5:0] found_position,
  output logic hit,
  output logic [6:0] match_total,
  output logic [1:0] status
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_MWR = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int AW = bvte_pkg::AW;
  localparam int CW = bvte_pkg::CW;
  localparam int WB = bvte_pkg::WORD_BITS;

  logic [2:0] state;
  logic [CW-1:0] count;
  logic [3:0] op;
  logic [WB-1:0] val;
  logic [CW-1:0] idx;
  logic [CW-1:0] stop;
  logic [AW-1:0] firstpos;
  logic found;
  logic [CW-1:0] total;
  logic alleq;
  logic [1:0] st;
  logic [WB-1:0] got;
  bvte_pkg::mem_req_t req;
  logic [WB-1:0] rdata;
  logic [CW-1:0] pos_ext;
  logic match;

  bvte_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign pos_ext = CW'(position);
  assign busy = (state != S_IDLE);
  assign match = (rdata == val);

  always_comb begin
    req = '0;
    unique case (state)
      S_IDLE: begin
        req.raddr = AW'(count - CW'(1));
        if (start && opcode == bvte_pkg::OP_PUSH && count < CW'(bvte_pkg::DEPTH)) begin
          req.we = 1'b1;
          req.waddr = AW'(count);
          req.wdata = WB'(word);
        end else if (start && opcode == bvte_pkg::OP_WRITE && pos_ext < count) begin
          req.we = 1'b1;
          req.waddr = AW'(position);
          req.wdata = WB'(word);
        end else if (start && (opcode == bvte_pkg::OP_READ || opcode == bvte_pkg::OP_DEL
                               || opcode == bvte_pkg::OP_FIND || opcode == bvte_pkg::OP_COUNT)) begin
          req.raddr = AW'(position);
        end else if (start && opcode == bvte_pkg::OP_ALLEQ) begin
          req.raddr = '0;
        end else if (start && opcode == bvte_pkg::OP_INS) begin
          req.raddr = AW'(count - CW'(1));
        end
      end
      S_SCAN: req.raddr = AW'(idx + CW'(1));
      S_MOVE: req.raddr = AW'(idx);
      S_MWR: begin
        req.we = 1'b1;
        req.wdata = rdata;
        if (op == bvte_pkg::OP_INS) begin
          req.waddr = AW'(idx + CW'(1));
          req.raddr = AW'(idx - CW'(1));
        end else begin
          req.waddr = AW'(idx - CW'(1));
          req.raddr = AW'(idx + CW'(1));
        end
      end
      S_RD: req.raddr = AW'(idx);
      S_DONE: begin
        if (op == bvte_pkg::OP_INS && st == bvte_pkg::ST_OK) begin
          req.we = 1'b1;
          req.waddr = firstpos;
          req.wdata = val;
        end
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= opcode;
            val <= WB'(word);
            firstpos <= AW'(position);
            found <= 1'b0;
            total <= '0;
            alleq <= 1'b1;
            got <= '0;
            st <= bvte_pkg::ST_OK;
            idx <= pos_ext;
            stop <= count;
            state <= S_DONE;
            case (opcode)
              bvte_pkg::OP_PUSH: begin
                if (count < CW'(bvte_pkg::DEPTH)) count <= count + CW'(1);
                else st <= bvte_pkg::ST_FULL;
              end
              bvte_pkg::OP_POP: begin
                if (count == '0) st <= bvte_pkg::ST_EMPTY;
                else begin
                  count <= count - CW'(1);
                  state <= S_RD;
                end
              end
              bvte_pkg::OP_INS: begin
                if (pos_ext >= count) st <= bvte_pkg::ST_OOB;
                else if (count >= CW'(bvte_pkg::DEPTH)) st <= bvte_pkg::ST_FULL;
                else begin
                  count <= count + CW'(1);
                  idx <= count - CW'(1);
                  state <= S_RD;
                end
              end
              bvte_pkg::OP_DEL: begin
                if (pos_ext >= count) st <= bvte_pkg::ST_OOB;
                else begin
                  count <= count - CW'(1);
                  state <= S_RD;
                end
              end
              bvte_pkg::OP_READ: begin
                if (pos_ext >= count) st <= bvte_pkg::ST_OOB;
                else state <= S_RD;
              end
              bvte_pkg::OP_WRITE: begin
                if (pos_ext >= count) st <= bvte_pkg::ST_OOB;
              end
              bvte_pkg::OP_FIND, bvte_pkg::OP_COUNT: begin
                if (pos_ext >= count) st <= bvte_pkg::ST_OOB;
                else state <= S_SCAN;
              end
              bvte_pkg::OP_ALLEQ: begin
                idx <= '0;
                if (count == '0) begin
                  st <= bvte_pkg::ST_OOB;
                  alleq <= 1'b0;
                end else state <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          if (op == bvte_pkg::OP_INS) begin
            state <= S_MWR;
          end else begin
            got <= rdata;
            if (op == bvte_pkg::OP_DEL) begin
              idx <= idx + CW'(1);
              state <= (idx + CW'(1) < stop) ? S_MOVE : S_DONE;
            end else state <= S_DONE;
          end
        end
        S_MOVE: state <= S_MWR;
        S_MWR: begin
          if (op == bvte_pkg::OP_INS) begin
            if (idx == CW'(firstpos)) state <= S_DONE;
            else begin
              idx <= idx - CW'(1);
              state <= S_MWR;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= (idx + CW'(1) < stop) ? S_MWR : S_DONE;
          end
        end
        S_SCAN: begin
          if (match) begin
            total <= total + CW'(1);
            if (!found && op == bvte_pkg::OP_FIND) begin
              found <= 1'b1;
              firstpos <= AW'(idx);
            end
          end else alleq <= 1'b0;
          idx <= idx + CW'(1);
          if (idx + CW'(1) >= stop || (op == bvte_pkg::OP_FIND && match)) state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          read_word <= 32'(got);
          found_position <= (op == bvte_pkg::OP_FIND && found) ? 6'(firstpos) : 6'd0;
          hit <= (op == bvte_pkg::OP_FIND) ? found
                 : (op == bvte_pkg::OP_ALLEQ && st == bvte_pkg::ST_OK) ? alleq : 1'b0;
          match_total <= (op == bvte_pkg::OP_COUNT) ? 7'(total) : 7'd0;
          status <= st;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_cnt_range, clk, rst, 1'b1, count <= CW'(bvte_pkg::DEPTH))
  `ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `ASSERT_NXT(a_take, clk, rst, start && !busy, busy)
  `ASSERT_IMP(a_done_pulse, clk, rst, done, $past(state) == S_DONE)
endmodule

// ===== tb/sv/bounded_vector_table_engine_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_table_engine_unit_checker
// Watches the command and result channels of the vector table engine, keeps
// its own copy of the table, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module bounded_vector_table_engine_unit_checker (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  logic [3:0] opcode,
  input  logic [5:0] position,
  input  logic [31:0] word,
  input  logic done,
  input  logic [31:0] read_word,
  input  logic [5:0] found_position,
  input  logic hit,
  input  logic [6:0] match_total,
  input  logic [1:0] status,
  output int fail_count,
  output int pending
);
  typedef struct packed {
    logic [31:0] rword;
    logic [5:0] fpos;
    logic hit;
    logic [6:0] total;
    logic [1:0] st;
  } outcome_t;

  logic [31:0] table_model [bvte_pkg::DEPTH];
  int fill;
  outcome_t expected_q [$];

  assign pending = expected_q.size();

  function automatic outcome_t apply_command(logic [3:0] op, logic [5:0] p, logic [31:0] w);
    outcome_t r;
    int n;
    r = '0;
    n = fill;
    case (op)
      bvte_pkg::OP_PUSH: begin
        if (n >= bvte_pkg::DEPTH) r.st = bvte_pkg::ST_FULL;
        else begin
          table_model[n] = w;
          fill = n + 1;
        end
      end
      bvte_pkg::OP_POP: begin
        if (n == 0) r.st = bvte_pkg::ST_EMPTY;
        else begin
          r.rword = table_model[n-1];
          fill = n - 1;
        end
      end
      bvte_pkg::OP_INS: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else if (n >= bvte_pkg::DEPTH) r.st = bvte_pkg::ST_FULL;
        else begin
          for (int i = n; i > p; i--) table_model[i] = table_model[i-1];
          table_model[p] = w;
          fill = n + 1;
        end
      end
      bvte_pkg::OP_DEL: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else begin
          r.rword = table_model[p];
          for (int i = p; i + 1 < n; i++) table_model[i] = table_model[i+1];
          fill = n - 1;
        end
      end
      bvte_pkg::OP_READ: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else r.rword = table_model[p];
      end
      bvte_pkg::OP_WRITE: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else table_model[p] = w;
      end
      bvte_pkg::OP_FIND: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else begin
          for (int i = p; i < n; i++)
            if (table_model[i] == w) begin
              r.fpos = i[5:0];
              r.hit = 1'b1;
              break;
            end
        end
      end
      bvte_pkg::OP_COUNT: begin
        if (p >= n) r.st = bvte_pkg::ST_OOB;
        else for (int i = p; i < n; i++) if (table_model[i] == w) r.total++;
      end
      bvte_pkg::OP_ALLEQ: begin
        if (n == 0) r.st = bvte_pkg::ST_OOB;
        else begin
          r.hit = 1'b1;
          for (int i = 0; i < n; i++) if (table_model[i] != w) r.hit = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t got, want;
    if (rst) begin
      fill = 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (done) begin
        got = '{read_word, found_position, hit, match_total, status};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected rw=%h pos=%0d hit=%b tot=%0d st=%0d",
                     $time, want.rword, want.fpos, want.hit, want.total, want.st);
            $display("%0t:          actual   rw=%h pos=%0d hit=%b tot=%0d st=%0d",
                     $time, got.rword, got.fpos, got.hit, got.total, got.st);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_q.push_back(apply_command(opcode, position, word));
    end
  end
endmodule

// ===== tb/sv/bounded_vector_table_engine_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_vector_table_engine_unit_tb
// Drives directed and random table commands with random sender gaps and
// gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module bounded_vector_table_engine_unit_tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] opcode = '0;
  logic [5:0] position = '0;
  logic [31:0] word = '0;
  logic busy, done, hit;
  logic [31:0] read_word;
  logic [5:0] found_position;
  logic [6:0] match_total;
  logic [1:0] status;
  int fail_count, pending;
  int level;
  int gap_pct;
  longint cycles = 0;
  logic [31:0] palette [4];

  localparam longint CYCLE_LIMIT = 2_000_000;

  always #1 clk = ~clk;

  bounded_vector_table_engine_unit dut (.*);

  bounded_vector_table_engine_unit_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bounded_vector_table_engine_unit test failed");
      $finish;
    end
  end

  // tracks fill level to keep random commands mostly in bounds
  task automatic issue(logic [3:0] op, logic [5:0] p, logic [31:0] w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    position <= p;
    word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      bvte_pkg::OP_PUSH: if (level < bvte_pkg::DEPTH) level++;
      bvte_pkg::OP_POP: if (level > 0) level--;
      bvte_pkg::OP_INS: if (p < level && level < bvte_pkg::DEPTH) level++;
      bvte_pkg::OP_DEL: if (p < level) level--;
      default: ;
    endcase
  endtask

  function automatic logic [5:0] pick_pos();
    if (level > 0 && $urandom_range(9) != 0) return 6'($urandom_range(level - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [31:0] pick_word();
    if ($urandom_range(2) != 0) return palette[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic random_phase(int n);
    logic [3:0] op;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 3) op = 4'($urandom_range(9, 15));
      else if (level < 8 && r < 40) op = bvte_pkg::OP_PUSH;
      else if (level > 56 && r < 40) op = bvte_pkg::OP_POP;
      else op = 4'($urandom_range(0, 8));
      issue(op, pick_pos(), pick_word());
    end
  endtask

  initial begin
    level = 0;
    gap_pct = 0;
    palette = '{32'h0, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 32'h1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // empty-table errors, then directed commands on a small table
    issue(bvte_pkg::OP_POP, 0, 0);
    issue(bvte_pkg::OP_ALLEQ, 0, 0);
    issue(bvte_pkg::OP_READ, 0, 0);
    issue(bvte_pkg::OP_FIND, 0, 0);
    issue(bvte_pkg::OP_INS, 0, 1);
    issue(4'd15, 6'd63, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_PUSH, 0, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_PUSH, 0, 32'h0);
    issue(bvte_pkg::OP_INS, 0, 32'h1234_5678);
    issue(bvte_pkg::OP_WRITE, 2, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_FIND, 1, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_COUNT, 0, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_ALLEQ, 0, 32'hFFFF_FFFF);
    issue(bvte_pkg::OP_DEL, 0, 0);
    issue(bvte_pkg::OP_READ, 6'd63, 0);
    issue(bvte_pkg::OP_WRITE, 5, 0);
    issue(4'd9, 0, 0);
    // fill to full, then full errors, full scans and deletes
    while (level < bvte_pkg::DEPTH) issue(bvte_pkg::OP_PUSH, 0, 32'hA5A5_A5A5);
    issue(bvte_pkg::OP_PUSH, 0, 1);
    issue(bvte_pkg::OP_INS, 6'd10, 1);
    issue(bvte_pkg::OP_ALLEQ, 0, 32'hA5A5_A5A5);
    issue(bvte_pkg::OP_COUNT, 0, 32'hA5A5_A5A5);
    issue(bvte_pkg::OP_FIND, 6'd63, 32'hA5A5_A5A5);
    issue(bvte_pkg::OP_DEL, 6'd63, 0);
    issue(bvte_pkg::OP_DEL, 0, 0);
    gap_pct = 25;
    random_phase(600);
    gap_pct = 86;
    random_phase(600);
    gap_pct = 0;
    random_phase(600);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_vector_table_engine_unit test passed");
    end else begin
      $display("bounded_vector_table_engine_unit test failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/bvte_pkg.sv
src/bvte_ram.sv
src/bounded_vector_table_engine_unit.sv
tb/sv/bounded_vector_table_engine_unit_checker.sv
tb/sv/bounded_vector_table_engine_unit_tb.sv
